// ===== hw/rtl/bmh_pkg.sv =====
// Shared constants and types for the bytewise MurmurHash3 block.
// Used by the controller, the datapath and the top level.
package bmh_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    // Controller-to-datapath command strobes, at most one step a cycle
    typedef struct packed {
        logic load;    // capture the input byte
        logic start;   // open a message: hash from seed, count from zero
        logic mix1;    // k = byte * c1
        logic mix2;    // k = rotl(k, 15) * c2
        logic absorb;  // fold k into the running hash, count the byte
        logic fin1;    // first finalizer multiply
        logic fin2;    // second finalizer multiply
        logic emit;    // load the output register
    } bmh_cmd_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
        logic [31:0] res;
        res = (v << r) | (v >> (32 - r));
        return res;
    endfunction

endpackage

// ===== hw/rtl/bytewise_murmur3_hash.sv =====
// Bytewise MurmurHash3 x86_32 hasher: each input beat carries one byte
// (tuser = has_byte) and optionally closes the message (tlast); a closing beat
// yields one 32-bit hash on the master side. A beat with a byte passes accept,
// the two-step byte mixer and the hash update; a closing beat then adds the two
// finalizer multiplies and the output load, which an empty closing beat enters
// straight from accept. A beat with neither a byte nor an end is dropped
// in its accept cycle. The sequencer handles one beat at a time, and the rate
// is set by the serial mixer and finalizer steps, one 32-bit multiply per
// cycle. The seed is sampled when a message begins; a finished hash waits in
// the output register while the next message is being taken in, and the next
// closing beat holds in its output load step until that hash has been read.
module bytewise_murmur3_hash
    import bmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] has_byte
    input  logic        s_tlast,    // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] hash_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    bmh_cmd_t cmd;

    assign cfg_ready = 1'b1;

    bmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bmh_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .data_byte  (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .hash_value (m_tdata)
    );

endmodule

// ===== hw/rtl/bmh_ctrl.sv =====
// Sequencing state machine for the bytewise MurmurHash3 block.
// Depends on bmh_pkg; drives bmh_datapath through a command struct.
module bmh_ctrl
    import bmh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     s_tuser,
    input  logic     s_tlast,
    output logic     m_tvalid,
    input  logic     m_tready,
    output bmh_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_ABSORB,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3
    } state_t;

    state_t state_reg, state_next;
    logic   in_message_reg, in_message_next;
    logic   eom_reg, eom_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next      = state_reg;
        in_message_next = in_message_reg;
        eom_next        = eom_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        cmd             = '0;
        case (state_reg)
            ST_IDLE:
            begin
                // drop beats that carry neither a byte nor an end
                if (accept && (s_tuser || s_tlast))
                begin
                    cmd.load        = 1'b1;
                    cmd.start       = !in_message_reg;
                    in_message_next = 1'b1;
                    eom_next        = s_tlast;
                    state_next      = s_tuser ? ST_MIX1 : ST_FIN1;
                end
            end
            ST_MIX1:
            begin
                cmd.mix1   = 1'b1;
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                cmd.mix2   = 1'b1;
                state_next = ST_ABSORB;
            end
            ST_ABSORB:
            begin
                cmd.absorb = 1'b1;
                state_next = eom_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                cmd.fin2   = 1'b1;
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.emit        = 1'b1;
                    out_valid_next  = 1'b1;
                    in_message_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            in_message_reg <= 1'b0;
            eom_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            in_message_reg <= in_message_next;
            eom_reg        <= eom_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result emitted over an unconsumed result");

    a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN3))
        else $error("result valid raised outside the final step");

    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !in_message_reg && (state_reg == ST_IDLE))
        else $error("message not closed after emit");

    a_byte_mixes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser) |=> (state_reg == ST_MIX1))
        else $error("byte beat did not enter the mixer");

endmodule

// ===== hw/rtl/bmh_datapath.sv =====
// Datapath for the bytewise MurmurHash3 block: seed, running hash, byte count,
// mixer and finalizer registers. Depends on bmh_pkg; stepped by bmh_ctrl.
module bmh_datapath
    import bmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bmh_cmd_t    cmd,
    input  logic [7:0]  data_byte,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    output logic [31:0] hash_value
);

    logic [31:0] seed_reg;
    logic [31:0] hash_reg;
    logic [31:0] count_reg;
    logic [7:0]  byte_reg;
    logic [31:0] k_reg;
    logic [31:0] f_reg;
    logic [31:0] out_reg;

    logic [31:0] h_xk;
    logic [31:0] h_rot;
    logic [31:0] h_fold;
    logic [31:0] f_mix2;

    assign h_xk   = rotl32(hash_reg ^ k_reg, 13);
    assign h_rot  = h_xk;
    assign h_fold = hash_reg ^ count_reg;
    assign f_mix2 = f_reg ^ (f_reg >> 13);
    assign hash_value = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_valid)
        begin
            seed_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= data_byte;
        end
        if (cmd.start)
        begin
            hash_reg  <= seed_reg;
            count_reg <= '0;
        end
        else if (cmd.absorb)
        begin
            // h * 5 + add as shift and add
            hash_reg  <= (h_rot << 2) + h_rot + MIX_ADD;
            count_reg <= count_reg + 32'd1;
        end
        if (cmd.mix1)
        begin
            k_reg <= {24'd0, byte_reg} * MIX_C1;
        end
        else if (cmd.mix2)
        begin
            k_reg <= rotl32(k_reg, 15) * MIX_C2;
        end
        if (cmd.fin1)
        begin
            f_reg <= (h_fold ^ (h_fold >> 16)) * FIN_M1;
        end
        else if (cmd.fin2)
        begin
            f_reg <= f_mix2 * FIN_M2;
        end
        if (cmd.emit)
        begin
            out_reg <= f_reg ^ (f_reg >> 16);
        end
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for bytewise_murmur3_hash: streams byte messages,
// predicts each finalized hash and checks it against the master-side beats.
// Depends only on the bytewise_murmur3_hash RTL and its package.
`timescale 1ns / 1ps

module testbench;

    localparam logic [31:0] K_MUL1   = 32'hcc9e2d51;
    localparam logic [31:0] K_MUL2   = 32'h1b873593;
    localparam logic [31:0] H_OFFSET = 32'he6546b64;
    localparam logic [31:0] F_MUL1   = 32'h85ebca6b;
    localparam logic [31:0] F_MUL2   = 32'hc2b2ae35;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_message;
    } msg_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic        s_tuser;     // [0] has_byte
    logic        s_tlast;     // end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] hash_value
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    msg_beat_t   pending_beats[$];
    logic [31:0] expected_hashes[$];

    // predictor state
    logic [31:0] model_seed;
    logic [31:0] model_hash;
    logic [31:0] model_count;
    logic        model_open;

    logic        beat_taken;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          error_count;
    int          beats_accepted;
    int          hashes_checked;
    int          bytes_queued;
    int          cycle_count;

    bytewise_murmur3_hash i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] rotate_left(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] absorb_into_hash(input logic [31:0] h,
                                                     input logic [7:0] b);
        logic [31:0] k;
        k = {24'd0, b} * K_MUL1;
        k = rotate_left(k, 15) * K_MUL2;
        h = rotate_left(h ^ k, 13);
        return h * 32'd5 + H_OFFSET;
    endfunction

    function automatic logic [31:0] finalize_hash(input logic [31:0] h,
                                                  input logic [31:0] n);
        h = h ^ n;
        h = h ^ (h >> 16);
        h = h * F_MUL1;
        h = h ^ (h >> 13);
        h = h * F_MUL2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    task automatic predict_hash(input msg_beat_t beat);
        if (beat.has_byte || beat.end_of_message)
        begin
            // a message picks up the seed only when it opens
            if (!model_open)
            begin
                model_hash  = model_seed;
                model_count = 32'd0;
                model_open  = 1'b1;
            end
            if (beat.has_byte)
            begin
                model_hash  = absorb_into_hash(model_hash, beat.data_byte);
                model_count = model_count + 32'd1;
            end
            if (beat.end_of_message)
            begin
                expected_hashes.push_back(finalize_hash(model_hash, model_count));
                model_hash  = model_seed;
                model_count = 32'd0;
                model_open  = 1'b0;
            end
        end
    endtask

    // driver: present the next pending beat, hold it until taken
    always @(negedge clk)
    begin : drive_stream
        logic launch;
        launch = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && !beat_taken)
                launch = 1'b1;
            else
            begin
                launch = (pending_beats.size() > 0) &&
                         ($urandom_range(99) >= send_idle_pct);
                if (launch)
                begin
                    s_tuser <= pending_beats[0].has_byte;
                    s_tdata <= pending_beats[0].data_byte;
                    s_tlast <= pending_beats[0].end_of_message;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
        s_tvalid <= launch;
    end

    // monitor: predict on accepted input beats, check output beats
    always @(posedge clk)
    begin : watch_stream
        logic [31:0] want;
        beat_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_hash('{has_byte: s_tuser, data_byte: s_tdata, end_of_message: s_tlast});
            void'(pending_beats.pop_front());
            beats_accepted++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_hashes.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected hash beat: got %08h", m_tdata);
            end
            else
            begin
                want = expected_hashes.pop_front();
                hashes_checked++;
                if (m_tdata !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("hash mismatch: expected %08h, got %08h", want, m_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("bytewise_murmur3_hash test failed");
            $finish;
        end
    end

    task automatic push_beat(input logic has_byte, input logic [7:0] data_byte,
                             input logic end_of_message);
        pending_beats.push_back('{has_byte, data_byte, end_of_message});
        if (has_byte || end_of_message)
            bytes_queued++;
    endtask

    // wait for every beat to go out and every hash to come back, then settle
    task automatic drain_block();
        while (pending_beats.size() != 0 || expected_hashes.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_seed = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_random_message();
        int len;
        int pick;
        logic empty_close;
        pick = $urandom_range(99);
        if (pick < 5)
            len = 0;
        else if (pick < 92)
            len = $urandom_range(12, 1);
        else
            len = $urandom_range(60, 13);
        empty_close = (len == 0) || ($urandom_range(99) < 20);
        for (int i = 0; i < len; i++)
        begin
            // sprinkle beats that carry neither a byte nor an end
            if ($urandom_range(99) < 8)
                push_beat(1'b0, 8'($urandom), 1'b0);
            push_beat(1'b1, 8'($urandom), (i == len - 1) && !empty_close);
        end
        if (empty_close)
            push_beat(1'b0, 8'($urandom), 1'b1);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct,
                             input logic [31:0] seed, input int beat_goal);
        int target;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_seed(seed);
        target = bytes_queued + beat_goal;
        while (bytes_queued < target)
        begin
            add_random_message();
            // let the sender go quiet now and then until all hashes are back
            if ($urandom_range(99) < 3)
                drain_block();
        end
        drain_block();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'd0;
        s_tuser        = 1'b0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 32'd0;
        beat_taken     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        beats_accepted = 0;
        hashes_checked = 0;
        bytes_queued   = 0;
        cycle_count    = 0;
        model_seed     = 32'd0;
        model_hash     = 32'd0;
        model_count    = 32'd0;
        model_open     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset seed, empty message, single extreme bytes, empty close
        push_beat(1'b0, 8'ha5, 1'b0);
        push_beat(1'b0, 8'h00, 1'b1);
        push_beat(1'b1, 8'h00, 1'b1);
        push_beat(1'b1, 8'hff, 1'b1);
        push_beat(1'b1, 8'h01, 1'b0);
        push_beat(1'b0, 8'h3c, 1'b0);
        push_beat(1'b1, 8'h80, 1'b0);
        push_beat(1'b1, 8'h7f, 1'b0);
        push_beat(1'b0, 8'hff, 1'b1);
        drain_block();

        write_seed(32'hffffffff);
        push_beat(1'b0, 8'h00, 1'b1);
        push_beat(1'b1, 8'h55, 1'b1);
        push_beat(1'b1, 8'haa, 1'b0);
        push_beat(1'b1, 8'hff, 1'b1);
        // leave a message open across a seed change
        push_beat(1'b1, 8'h12, 1'b0);
        push_beat(1'b1, 8'h34, 1'b0);
        drain_block();
        write_seed(32'h9e3779b9);
        push_beat(1'b1, 8'h56, 1'b0);
        push_beat(1'b0, 8'h00, 1'b1);
        push_beat(1'b0, 8'h00, 1'b1);
        drain_block();

        run_phase(0, 0, 32'h00000000, 250);
        run_phase(56, 0, $urandom, 250);
        run_phase(0, 56, 32'hffffffff, 250);
        run_phase(38, 38, $urandom, 250);

        if (expected_hashes.size() != 0)
        begin
            error_count += expected_hashes.size();
            $display("%0d expected hashes never arrived", expected_hashes.size());
        end
        $display("covered %0d input beats and %0d checked hashes over five seeds,",
                 beats_accepted, hashes_checked);
        $display("with empty messages, open-message seed change and random back-pressure");
        if (error_count == 0)
            $display("bytewise_murmur3_hash test passed");
        else
            $display("bytewise_murmur3_hash test failed");
        $finish;
    end

endmodule
